// ===== sv/assert_macros.svh =====
// Assertion macros used by the heap core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge out of reset.
`define ASSERT_ALWAYS(lbl, expr, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) else $error(msg);

// Implication checked in the same cycle.
`define ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ===== sv/iwmh_pkg.sv =====
// Types and codes of the indexed wake-up min-heap.
package iwmh_pkg;

    localparam logic [1:0] CMD_PUSH   = 2'd0;
    localparam logic [1:0] CMD_POP    = 2'd1;
    localparam logic [1:0] CMD_REMOVE = 2'd2;
    localparam logic [1:0] CMD_EXPIRE = 2'd3;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_EMPTY   = 3'd1;
    localparam logic [2:0] ST_ABSENT  = 3'd2;
    localparam logic [2:0] ST_FULL    = 3'd3;
    localparam logic [2:0] ST_PRESENT = 3'd4;
    localparam logic [2:0] ST_NONE    = 3'd5;

    // Most entries one expire command may release.
    localparam int unsigned MAX_OUT = 64;

    typedef struct packed {
        logic [5:0]  id;
        logic [63:0] key;
    } t_entry;

    typedef struct packed {
        logic [1:0]  command;
        logic [5:0]  thread_id;
        logic [63:0] wakeup_time;
        logic [63:0] current_time;
    } t_cmd_item;

    typedef struct packed {
        logic [5:0]  out_thread_id;
        logic [63:0] out_wakeup_time;
        logic [2:0]  status;
        logic        last;
        logic [6:0]  entry_count;
        logic [63:0] front_time;
    } t_res_item;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_EXP_CHK,
        S_TAKE_RD,
        S_TAKE_TAIL,
        S_TAKE_LATCH,
        S_UP_RD,
        S_UP_CMP,
        S_DN_RD1,
        S_DN_RD2,
        S_DN_CMP,
        S_EMIT
    } t_state;

endpackage

// ===== sv/iwmh_stream_if.sv =====
// Valid/ready channel carrying one item of a given payload type.
interface iwmh_stream_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== sv/indexed_wakeup_min_heap_core.sv =====
// Indexed wake-up min-heap: heap and position memories with a sift sequencer.
//
//  channel | dir | payload    | accepted when
//  i_cmd   | in  | t_cmd_item | valid && ready
//  o_res   | out | t_res_item | valid && ready
//
// One command at a time; ready is high only while the sequencer is idle.
// Push sifts the new entry up from the tail. Pop and remove read the taken entry and the tail,
// put the tail into the freed slot unless that slot is the tail, and sift it up, or else down.
// A level up reads the parent, a level down both children.
// Expire passes a check state and then the pop sequence once per due entry, one result each.
// Reset is synchronous and clears the state, the size, the presence bits and the output valid only.
// A result waits in the output register; the sequencer stalls there if it is not taken.
`include "assert_macros.svh"

module indexed_wakeup_min_heap_core #(
    parameter int CAPACITY = 64,
    parameter int ID_COUNT = 64
) (
    input  logic i_clk,
    input  logic i_rst_n,
    iwmh_stream_if.sink   i_cmd,
    iwmh_stream_if.source o_res
);
    localparam int PW  = $clog2(CAPACITY);
    localparam int SW  = $clog2(CAPACITY + 1);
    localparam int IDW = $clog2(ID_COUNT);

    iwmh_pkg::t_state    r_state, n_state;
    iwmh_pkg::t_cmd_item r_cmd, n_cmd;
    logic [SW-1:0]       r_size, n_size;
    logic [ID_COUNT-1:0] r_present, n_present;
    logic [PW-1:0]       r_hole, n_hole;
    logic [PW-1:0]       r_slot, n_slot;
    iwmh_pkg::t_entry    r_e, n_e;
    iwmh_pkg::t_entry    r_cbuf, n_cbuf;
    iwmh_pkg::t_entry    r_res, n_res;
    logic [2:0]          r_status, n_status;
    logic                r_moved, n_moved;
    logic                r_two, n_two;
    logic [6:0]          r_n, n_n;
    logic [63:0]         r_front, n_front;
    iwmh_pkg::t_res_item r_out, n_out;
    logic                r_ovalid, n_ovalid;

    // Heap and position memories.
    iwmh_pkg::t_entry r_heap [CAPACITY];
    iwmh_pkg::t_entry r_heap_q;
    logic [PW-1:0]    r_pos [ID_COUNT];
    logic [PW-1:0]    r_pos_q;

    logic             heap_we, heap_re, pos_we;
    logic [PW-1:0]    heap_waddr, heap_raddr, pos_wdata;
    logic [IDW-1:0]   pos_waddr, pos_raddr;
    iwmh_pkg::t_entry heap_wdata;

    always_ff @(posedge i_clk) begin
        if (heap_we) r_heap[heap_waddr] <= heap_wdata;
        if (heap_re) r_heap_q <= r_heap[heap_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (pos_we) r_pos[pos_waddr] <= pos_wdata;
        r_pos_q <= r_pos[pos_raddr];
    end

    logic           w_accept, w_out_free;
    logic           w_tid_ok;
    logic [IDW-1:0] w_tid_idx;
    logic [PW-1:0]  w_tail, w_parent;
    logic [PW+1:0]  w_c0, w_c1, w_size_x;
    logic           w_has_c0, w_has_c1;
    logic           w_pick1, w_sink, w_exp_due, w_more;
    iwmh_pkg::t_entry w_pick;
    logic [PW-1:0]  w_pick_idx;

    assign w_accept   = i_cmd.valid && i_cmd.ready;
    assign w_out_free = !r_ovalid || o_res.ready;
    assign w_tid_ok   = 32'(r_cmd.thread_id) < ID_COUNT;
    assign w_tid_idx  = IDW'(r_cmd.thread_id);
    assign w_tail     = PW'(r_size - SW'(1));
    assign w_parent   = (r_hole - PW'(1)) >> 1;
    assign w_c0       = {1'b0, r_hole, 1'b1};
    assign w_c1       = w_c0 + (PW+2)'(1);
    assign w_size_x   = (PW+2)'(r_size);
    assign w_has_c0   = w_c0 < w_size_x;
    assign w_has_c1   = w_c1 < w_size_x;
    assign w_pick1    = r_two && (r_heap_q.key < r_cbuf.key);
    assign w_pick     = w_pick1 ? r_heap_q : r_cbuf;
    assign w_pick_idx = w_pick1 ? PW'(w_c1) : PW'(w_c0);
    assign w_sink     = w_pick.key < r_e.key;
    assign w_exp_due  = (r_n < 7'(iwmh_pkg::MAX_OUT)) && (r_size != '0)
                        && !(r_cmd.current_time < r_front);
    // Another expire result follows the one now being sent.
    assign w_more     = (r_cmd.command == iwmh_pkg::CMD_EXPIRE)
                        && (r_status == iwmh_pkg::ST_OK)
                        && (32'(r_n) + 1 < iwmh_pkg::MAX_OUT) && (r_size != '0)
                        && !(r_cmd.current_time < r_front);

    assign i_cmd.ready = (r_state == iwmh_pkg::S_IDLE);
    assign o_res.valid = r_ovalid;
    assign o_res.data  = r_out;

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            iwmh_pkg::S_IDLE: begin
                if (w_accept) n_state = iwmh_pkg::S_CHECK;
            end
            iwmh_pkg::S_CHECK: begin
                case (r_cmd.command)
                    iwmh_pkg::CMD_PUSH: begin
                        if (w_tid_ok && !r_present[w_tid_idx] && (32'(r_size) < CAPACITY))
                            n_state = iwmh_pkg::S_UP_RD;
                        else
                            n_state = iwmh_pkg::S_EMIT;
                    end
                    iwmh_pkg::CMD_POP: begin
                        n_state = (r_size == '0) ? iwmh_pkg::S_EMIT : iwmh_pkg::S_TAKE_RD;
                    end
                    iwmh_pkg::CMD_REMOVE: begin
                        if (w_tid_ok && r_present[w_tid_idx] && (SW'(r_pos_q) < r_size))
                            n_state = iwmh_pkg::S_TAKE_RD;
                        else
                            n_state = iwmh_pkg::S_EMIT;
                    end
                    default: n_state = iwmh_pkg::S_EXP_CHK;
                endcase
            end
            iwmh_pkg::S_EXP_CHK: begin
                n_state = w_exp_due ? iwmh_pkg::S_TAKE_RD : iwmh_pkg::S_EMIT;
            end
            iwmh_pkg::S_TAKE_RD:   n_state = iwmh_pkg::S_TAKE_TAIL;
            iwmh_pkg::S_TAKE_TAIL: n_state = iwmh_pkg::S_TAKE_LATCH;
            iwmh_pkg::S_TAKE_LATCH: begin
                n_state = (r_slot == w_tail) ? iwmh_pkg::S_EMIT : iwmh_pkg::S_UP_RD;
            end
            iwmh_pkg::S_UP_RD: begin
                if (r_hole != '0)
                    n_state = iwmh_pkg::S_UP_CMP;
                else if (r_cmd.command == iwmh_pkg::CMD_PUSH || r_moved)
                    n_state = iwmh_pkg::S_EMIT;
                else
                    n_state = iwmh_pkg::S_DN_RD1;
            end
            iwmh_pkg::S_UP_CMP: begin
                if (r_e.key < r_heap_q.key)
                    n_state = iwmh_pkg::S_UP_RD;
                else if (r_cmd.command == iwmh_pkg::CMD_PUSH || r_moved)
                    n_state = iwmh_pkg::S_EMIT;
                else
                    n_state = iwmh_pkg::S_DN_RD1;
            end
            iwmh_pkg::S_DN_RD1: begin
                n_state = w_has_c0 ? iwmh_pkg::S_DN_RD2 : iwmh_pkg::S_EMIT;
            end
            iwmh_pkg::S_DN_RD2: n_state = iwmh_pkg::S_DN_CMP;
            iwmh_pkg::S_DN_CMP: begin
                n_state = w_sink ? iwmh_pkg::S_DN_RD1 : iwmh_pkg::S_EMIT;
            end
            iwmh_pkg::S_EMIT: begin
                if (w_out_free)
                    n_state = w_more ? iwmh_pkg::S_EXP_CHK : iwmh_pkg::S_IDLE;
            end
            default: n_state = iwmh_pkg::S_IDLE;
        endcase
    end

    // Memory controls and datapath next values.
    always_comb begin
        n_cmd      = r_cmd;
        n_size     = r_size;
        n_present  = r_present;
        n_hole     = r_hole;
        n_slot     = r_slot;
        n_e        = r_e;
        n_cbuf     = r_cbuf;
        n_res      = r_res;
        n_status   = r_status;
        n_moved    = r_moved;
        n_two      = r_two;
        n_n        = r_n;
        n_out      = r_out;
        n_ovalid   = r_ovalid && !o_res.ready;
        heap_we    = 1'b0;
        heap_re    = 1'b0;
        pos_we     = 1'b0;
        heap_waddr = r_hole;
        heap_wdata = r_e;
        heap_raddr = r_slot;
        pos_waddr  = IDW'(r_e.id);
        pos_wdata  = r_hole;
        pos_raddr  = IDW'(i_cmd.data.thread_id);
        case (r_state)
            iwmh_pkg::S_IDLE: begin
                if (w_accept) n_cmd = i_cmd.data;
            end
            iwmh_pkg::S_CHECK: begin
                n_res    = '0;
                n_status = iwmh_pkg::ST_OK;
                n_n      = '0;
                n_moved  = 1'b0;
                case (r_cmd.command)
                    iwmh_pkg::CMD_PUSH: begin
                        if (!w_tid_ok) begin
                            n_status = iwmh_pkg::ST_ABSENT;
                        end else if (r_present[w_tid_idx]) begin
                            n_status = iwmh_pkg::ST_PRESENT;
                        end else if (!(32'(r_size) < CAPACITY)) begin
                            n_status = iwmh_pkg::ST_FULL;
                        end else begin
                            n_present[w_tid_idx] = 1'b1;
                            n_hole = PW'(r_size);
                            n_size = r_size + SW'(1);
                            n_e    = '{id: r_cmd.thread_id, key: r_cmd.wakeup_time};
                        end
                    end
                    iwmh_pkg::CMD_POP: begin
                        n_slot = '0;
                        if (r_size == '0) n_status = iwmh_pkg::ST_EMPTY;
                    end
                    iwmh_pkg::CMD_REMOVE: begin
                        n_slot = r_pos_q;
                        if (!(w_tid_ok && r_present[w_tid_idx] && (SW'(r_pos_q) < r_size)))
                            n_status = iwmh_pkg::ST_ABSENT;
                    end
                    default: ;
                endcase
            end
            iwmh_pkg::S_EXP_CHK: begin
                n_slot  = '0;
                n_moved = 1'b0;
                if (!w_exp_due) begin
                    n_res    = '0;
                    n_status = iwmh_pkg::ST_NONE;
                end
            end
            iwmh_pkg::S_TAKE_RD: begin
                heap_re    = 1'b1;
                heap_raddr = r_slot;
            end
            iwmh_pkg::S_TAKE_TAIL: begin
                n_res      = r_heap_q;
                heap_re    = 1'b1;
                heap_raddr = w_tail;
            end
            iwmh_pkg::S_TAKE_LATCH: begin
                n_present[IDW'(r_res.id)] = 1'b0;
                n_size   = r_size - SW'(1);
                n_status = iwmh_pkg::ST_OK;
                n_e      = r_heap_q;
                n_hole   = r_slot;
            end
            iwmh_pkg::S_UP_RD: begin
                if (r_hole != '0) begin
                    heap_re    = 1'b1;
                    heap_raddr = w_parent;
                end else begin
                    heap_we = 1'b1;
                    pos_we  = 1'b1;
                end
            end
            iwmh_pkg::S_UP_CMP: begin
                heap_we = 1'b1;
                pos_we  = 1'b1;
                if (r_e.key < r_heap_q.key) begin
                    heap_wdata = r_heap_q;
                    pos_waddr  = IDW'(r_heap_q.id);
                    n_hole     = w_parent;
                    n_moved    = 1'b1;
                end
            end
            iwmh_pkg::S_DN_RD1: begin
                if (w_has_c0) begin
                    heap_re    = 1'b1;
                    heap_raddr = PW'(w_c0);
                end else begin
                    heap_we = 1'b1;
                    pos_we  = 1'b1;
                end
            end
            iwmh_pkg::S_DN_RD2: begin
                n_cbuf = r_heap_q;
                n_two  = w_has_c1;
                if (w_has_c1) begin
                    heap_re    = 1'b1;
                    heap_raddr = PW'(w_c1);
                end
            end
            iwmh_pkg::S_DN_CMP: begin
                heap_we = 1'b1;
                pos_we  = 1'b1;
                if (w_sink) begin
                    heap_wdata = w_pick;
                    pos_waddr  = IDW'(w_pick.id);
                    n_hole     = w_pick_idx;
                end
            end
            iwmh_pkg::S_EMIT: begin
                if (w_out_free) begin
                    n_ovalid = 1'b1;
                    n_out.out_thread_id   = r_res.id;
                    n_out.out_wakeup_time = r_res.key;
                    n_out.status          = r_status;
                    n_out.last            = !w_more;
                    n_out.entry_count     = 7'(r_size);
                    n_out.front_time      = (r_size != '0) ? r_front : 64'd0;
                    if (r_cmd.command == iwmh_pkg::CMD_EXPIRE) n_n = r_n + 7'd1;
                end
            end
            default: ;
        endcase
        n_front = (heap_we && heap_waddr == '0) ? heap_wdata.key : r_front;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= iwmh_pkg::S_IDLE;
            r_size    <= '0;
            r_present <= '0;
            r_ovalid  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_size    <= n_size;
            r_present <= n_present;
            r_ovalid  <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd    <= n_cmd;
        r_hole   <= n_hole;
        r_slot   <= n_slot;
        r_e      <= n_e;
        r_cbuf   <= n_cbuf;
        r_res    <= n_res;
        r_status <= n_status;
        r_moved  <= n_moved;
        r_two    <= n_two;
        r_n      <= n_n;
        r_front  <= n_front;
        r_out    <= n_out;
    end

    `ASSERT_ALWAYS(a_size_bound, 32'(r_size) <= CAPACITY, "heap size exceeds capacity")
    `ASSERT_IMPL(a_hole_in_heap, r_state == iwmh_pkg::S_UP_RD || r_state == iwmh_pkg::S_DN_RD1, SW'(r_hole) < r_size, "sift hole lies outside the heap")
    `ASSERT_IMPL(a_more_needs_entry, r_ovalid && !r_out.last, r_out.entry_count != 7'd0 && r_out.status == iwmh_pkg::ST_OK, "non-final result with an empty heap")

endmodule

// ===== dv/tb_indexed_wakeup_min_heap_core.sv =====
// Testbench for the indexed wake-up min-heap: scoreboard against an internal heap predictor.
`timescale 1ns / 1ps

module tb_indexed_wakeup_min_heap_core;

    localparam int HEAP_CAP = 64;
    localparam int LIMIT_CYCLES = 1000000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    always #6 i_clk = ~i_clk;

    iwmh_stream_if #(.T(iwmh_pkg::t_cmd_item)) cmd_ch ();
    iwmh_stream_if #(.T(iwmh_pkg::t_res_item)) res_ch ();

    indexed_wakeup_min_heap_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_ch),
        .o_res   (res_ch)
    );

    // Predictor state: a heap of ids and keys plus a position table.
    logic [5:0]  hp_ids [HEAP_CAP];
    logic [63:0] hp_keys [HEAP_CAP];
    int          pos_of [64];
    bit          held [64];
    int          hp_size;

    iwmh_pkg::t_cmd_item pending_cmds [$];
    iwmh_pkg::t_res_item expected_res [$];
    int  fail_count;
    int  cycle_count;
    bit  driving_done;
    bit  quiet_tail;
    int  src_gap;
    int  snk_gap;

    function automatic void place(input int slot, input logic [5:0] id,
                                  input logic [63:0] key);
        hp_ids[slot] = id;
        hp_keys[slot] = key;
        pos_of[id] = slot;
    endfunction

    function automatic bit rise(input int start);
        int slot;
        int parent;
        logic [5:0] id;
        logic [63:0] key;
        bit moved;
        slot = start;
        id = hp_ids[slot];
        key = hp_keys[slot];
        moved = 0;
        while (slot != 0) begin
            parent = (slot - 1) >> 1;
            if (key < hp_keys[parent]) begin
                place(slot, hp_ids[parent], hp_keys[parent]);
                slot = parent;
                moved = 1;
            end else begin
                break;
            end
        end
        if (moved) place(slot, id, key);
        return moved;
    endfunction

    task automatic sink_down(input int start);
        int slot;
        int child;
        logic [5:0] id;
        logic [63:0] key;
        bit moved;
        slot = start;
        id = hp_ids[slot];
        key = hp_keys[slot];
        moved = 0;
        child = slot * 2 + 1;
        while (child < hp_size) begin
            if (child + 1 < hp_size && hp_keys[child + 1] < hp_keys[child]) child++;
            if (hp_keys[child] < key) begin
                place(slot, hp_ids[child], hp_keys[child]);
                slot = child;
                child = slot * 2 + 1;
                moved = 1;
            end else begin
                break;
            end
        end
        if (moved) place(slot, id, key);
    endtask

    task automatic extract(input int slot, output logic [5:0] id, output logic [63:0] key);
        int tail;
        tail = hp_size - 1;
        id = hp_ids[slot];
        key = hp_keys[slot];
        held[id] = 0;
        hp_size = tail;
        if (slot != tail) begin
            place(slot, hp_ids[tail], hp_keys[tail]);
            if (!rise(slot)) sink_down(slot);
        end
    endtask

    task automatic post_result(input logic [5:0] id, input logic [63:0] key,
                               input logic [2:0] st, input bit lst);
        iwmh_pkg::t_res_item r;
        r.out_thread_id = id;
        r.out_wakeup_time = key;
        r.status = st;
        r.last = lst;
        r.entry_count = 7'(hp_size);
        r.front_time = hp_size != 0 ? hp_keys[0] : 64'd0;
        expected_res.insert(expected_res.size(), r);
    endtask

    task automatic queue_cmd(input iwmh_pkg::t_cmd_item c);
        pending_cmds.insert(pending_cmds.size(), c);
    endtask

    task automatic predict_heap(input iwmh_pkg::t_cmd_item c);
        logic [5:0] id;
        logic [63:0] key;
        int n;
        case (c.command)
            iwmh_pkg::CMD_PUSH: begin
                if (held[c.thread_id]) post_result(0, 0, iwmh_pkg::ST_PRESENT, 1);
                else if (hp_size >= HEAP_CAP) post_result(0, 0, iwmh_pkg::ST_FULL, 1);
                else begin
                    held[c.thread_id] = 1;
                    place(hp_size, c.thread_id, c.wakeup_time);
                    hp_size++;
                    void'(rise(hp_size - 1));
                    post_result(0, 0, iwmh_pkg::ST_OK, 1);
                end
            end
            iwmh_pkg::CMD_POP: begin
                if (hp_size == 0) post_result(0, 0, iwmh_pkg::ST_EMPTY, 1);
                else begin
                    extract(0, id, key);
                    post_result(id, key, iwmh_pkg::ST_OK, 1);
                end
            end
            iwmh_pkg::CMD_REMOVE: begin
                if (!held[c.thread_id] || pos_of[c.thread_id] >= hp_size)
                    post_result(0, 0, iwmh_pkg::ST_ABSENT, 1);
                else begin
                    extract(pos_of[c.thread_id], id, key);
                    post_result(id, key, iwmh_pkg::ST_OK, 1);
                end
            end
            default: begin
                n = 0;
                while (n < iwmh_pkg::MAX_OUT && hp_size != 0
                       && !(c.current_time < hp_keys[0])) begin
                    extract(0, id, key);
                    post_result(id, key, iwmh_pkg::ST_OK, 0);
                    n++;
                end
                if (n == 0) post_result(0, 0, iwmh_pkg::ST_NONE, 1);
                else expected_res[$].last = 1;
            end
        endcase
    endtask

    // Driver: presents queued items, with random gaps until the quiet tail.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cmd_ch.valid <= 1'b0;
            cmd_ch.data <= '0;
            src_gap <= 0;
        end else begin
            if (cmd_ch.valid && cmd_ch.ready) predict_heap(cmd_ch.data);
            if (!cmd_ch.valid || cmd_ch.ready) begin
                if (src_gap > 0) begin
                    src_gap <= src_gap - 1;
                    cmd_ch.valid <= 1'b0;
                end else if (pending_cmds.size() != 0) begin
                    cmd_ch.data <= pending_cmds[0];
                    pending_cmds.delete(0);
                    cmd_ch.valid <= 1'b1;
                    if (!quiet_tail && $urandom_range(0, 7) == 0)
                        src_gap <= $urandom_range(1, 11);
                end else begin
                    cmd_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks each accepted result and paces ready.
    always @(posedge i_clk) begin
        iwmh_pkg::t_res_item exp_r;
        iwmh_pkg::t_res_item got;
        if (!i_rst_n) begin
            res_ch.ready <= 1'b0;
            snk_gap <= 0;
        end else begin
            if (res_ch.valid && res_ch.ready) begin
                got = res_ch.data;
                if (expected_res.size() == 0) begin
                    $error("result with no expectation waiting: %p", got);
                    fail_count++;
                end else begin
                    exp_r = expected_res[0];
                    expected_res.delete(0);
                    if (got.out_thread_id !== exp_r.out_thread_id) begin
                        $error("out_thread_id expected %0d actual %0d",
                               exp_r.out_thread_id, got.out_thread_id);
                        fail_count++;
                    end
                    if (got.out_wakeup_time !== exp_r.out_wakeup_time) begin
                        $error("out_wakeup_time expected %0h actual %0h",
                               exp_r.out_wakeup_time, got.out_wakeup_time);
                        fail_count++;
                    end
                    if (got.status !== exp_r.status) begin
                        $error("status expected %0d actual %0d", exp_r.status, got.status);
                        fail_count++;
                    end
                    if (got.last !== exp_r.last) begin
                        $error("last expected %0d actual %0d", exp_r.last, got.last);
                        fail_count++;
                    end
                    if (got.entry_count !== exp_r.entry_count) begin
                        $error("entry_count expected %0d actual %0d",
                               exp_r.entry_count, got.entry_count);
                        fail_count++;
                    end
                    if (got.front_time !== exp_r.front_time) begin
                        $error("front_time expected %0h actual %0h",
                               exp_r.front_time, got.front_time);
                        fail_count++;
                    end
                end
            end
            if (snk_gap > 0) begin
                snk_gap <= snk_gap - 1;
                res_ch.ready <= 1'b0;
            end else if (!quiet_tail && $urandom_range(0, 7) == 0) begin
                snk_gap <= $urandom_range(0, 10);
                res_ch.ready <= 1'b0;
            end else begin
                res_ch.ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("indexed_wakeup_min_heap_core verification failed");
            $finish;
        end
    end

    function automatic iwmh_pkg::t_cmd_item mk(input logic [1:0] cmd, input logic [5:0] id,
                                               input logic [63:0] wake,
                                               input logic [63:0] now);
        iwmh_pkg::t_cmd_item c;
        c.command = cmd;
        c.thread_id = id;
        c.wakeup_time = wake;
        c.current_time = now;
        return c;
    endfunction

    function automatic logic [63:0] rand_key();
        case ($urandom_range(0, 3))
            0: return 64'($urandom_range(0, 40));
            1: return {$urandom, $urandom};
            2: return 64'hFFFF_FFFF_FFFF_FFF0 | 64'($urandom_range(0, 15));
            default: return 64'($urandom_range(0, 1000));
        endcase
    endfunction

    initial begin
        logic [1:0] cmd;
        int k;
        fail_count = 0;
        cycle_count = 0;
        quiet_tail = 0;
        cmd_ch.valid = 1'b0;
        cmd_ch.data = '0;
        res_ch.ready = 1'b0;
        for (int i = 0; i < 64; i++) begin
            held[i] = 0;
            pos_of[i] = 0;
        end
        hp_size = 0;

        // Directed: empty cases, key extremes, ties, duplicates, remove, expire.
        queue_cmd(mk(iwmh_pkg::CMD_POP, 0, 0, 0));
        queue_cmd(mk(iwmh_pkg::CMD_REMOVE, 63, 0, 0));
        queue_cmd(mk(iwmh_pkg::CMD_EXPIRE, 0, 0, '1));
        queue_cmd(mk(iwmh_pkg::CMD_PUSH, 63, '1, 0));
        queue_cmd(mk(iwmh_pkg::CMD_PUSH, 0, 0, 0));
        queue_cmd(mk(iwmh_pkg::CMD_PUSH, 5, 100, 0));
        queue_cmd(mk(iwmh_pkg::CMD_PUSH, 6, 100, 0));
        queue_cmd(mk(iwmh_pkg::CMD_PUSH, 5, 7, 0));
        queue_cmd(mk(iwmh_pkg::CMD_PUSH, 42, 64'h5555_AAAA_5555_AAAA, '1));
        queue_cmd(mk(iwmh_pkg::CMD_EXPIRE, 0, 0, 99));
        queue_cmd(mk(iwmh_pkg::CMD_REMOVE, 6, 0, 0));
        queue_cmd(mk(iwmh_pkg::CMD_REMOVE, 6, 0, 0));
        queue_cmd(mk(iwmh_pkg::CMD_POP, 0, 0, 0));
        queue_cmd(mk(iwmh_pkg::CMD_EXPIRE, 0, 0, '1));
        // Fill to capacity, push a held id once, then one expire drains all 64.
        for (int i = 0; i < 64; i++)
            queue_cmd(mk(iwmh_pkg::CMD_PUSH, 6'(i), 64'($urandom_range(0, 5)), 0));
        queue_cmd(mk(iwmh_pkg::CMD_PUSH, 0, 1, 0));
        queue_cmd(mk(iwmh_pkg::CMD_EXPIRE, 0, 0, '1));

        // Random: half pushes, the rest pops, removes of random ids and expires.
        for (int i = 0; i < 270; i++) begin
            k = $urandom_range(0, 99);
            if (k < 50) cmd = iwmh_pkg::CMD_PUSH;
            else if (k < 65) cmd = iwmh_pkg::CMD_POP;
            else if (k < 85) cmd = iwmh_pkg::CMD_REMOVE;
            else cmd = iwmh_pkg::CMD_EXPIRE;
            queue_cmd(mk(cmd, 6'($urandom_range(0, 63)), rand_key(),
                         $urandom_range(0, 3) == 0 ? {$urandom, $urandom}
                                                   : 64'($urandom_range(0, 600))));
        end

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_cmds.size() >= 40) @(posedge i_clk);
        quiet_tail = 1;
        while (pending_cmds.size() != 0 || cmd_ch.valid) @(posedge i_clk);
        while (expected_res.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (fail_count == 0 && expected_res.size() == 0)
            $display("indexed_wakeup_min_heap_core verification clean");
        else
            $display("indexed_wakeup_min_heap_core verification failed");
        $finish;
    end

endmodule
